// ===== sv/gma_pkg.sv =====
// Shared constants, widths, command and register codes for the greedy assignment core.
package gma_pkg;

   localparam int MAX_ROWS   = 32;
   localparam int MAX_COLS   = 32;
   localparam int SCORE_BITS = 16;
   localparam int PAIR_LIMIT = 32;

   // Fixed widths of the transaction fields and registers.
   localparam int ROW_W   = 5;
   localparam int COL_W   = 5;
   localparam int IN_W    = 16;
   localparam int CFG_W   = 6;
   localparam int DIM_W   = CFG_W + 1;
   localparam int CSR_IDX_W = 2;

   localparam int RIDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CIDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_RUN  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_ROWS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COLS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MATCH = 2'd2;

   localparam logic [CFG_W-1:0] ROWS_RESET  = CFG_W'(32);
   localparam logic [CFG_W-1:0] COLS_RESET  = CFG_W'(32);
   localparam logic [CFG_W-1:0] MATCH_RESET = CFG_W'(1);

   localparam int SCORE_LO = -(2 ** (SCORE_BITS - 1));
   localparam int SCORE_HI = (2 ** (SCORE_BITS - 1)) - 1;

   // Saturates a 16-bit input score to the stored score width.
   function automatic logic [SCORE_BITS-1:0] fit_score(logic signed [IN_W-1:0] raw);
      int v;
      v = int'(raw);
      if (v < SCORE_LO) v = SCORE_LO;
      if (v > SCORE_HI) v = SCORE_HI;
      return SCORE_BITS'(v);
   endfunction

endpackage

// ===== sv/gma_if.sv =====
// Handshake interfaces for the request, response and register write channels.
interface gma_req_if;
   import gma_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    cmd;
   logic [ROW_W-1:0]        row;
   logic [COL_W-1:0]        col;
   logic signed [IN_W-1:0]  score;

   modport source (output valid, output cmd, output row, output col, output score,
                   input ready);
   modport sink   (input valid, input cmd, input row, input col, input score,
                   output ready);
endinterface

interface gma_rsp_if;
   import gma_pkg::*;
   logic             valid;
   logic             ready;
   logic [ROW_W-1:0] match_row;
   logic [COL_W-1:0] match_col;
   logic             found;
   logic             last;

   modport source (output valid, output match_row, output match_col, output found,
                   output last, input ready);
   modport sink   (input valid, input match_row, input match_col, input found,
                   input last, output ready);
endinterface

interface gma_csr_if;
   import gma_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/gma_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gma_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/greedy_max_assignment_core.sv =====
// Greedy maximum-weight assignment core: score store, scan sequencer and result register.
//
//   channel   direction  carries
//   req_chan  in         cmd, row, col, score (load one entry or start a run)
//   rsp_chan  out        match_row, match_col, found, last (pairs, then terminator)
//   csr_chan  in         index, data (rows_in_use, cols_in_use, match_count)
//
// A load writes its entry to the score store. A run, per round, reads all rows*cols
// entries in turn, then settles in DRAIN and decides in DECIDE, and ends with the
// terminator from TERM; the score store has a single read port, so entries are read one after another.
// Reset sets the registers to 32, 32 and 1 and clears the taken masks; the store
// is not cleared. A stalled response holds the sequencer only when it must emit.
module greedy_max_assignment_core (
   input  logic      clock,
   input  logic      reset,
   gma_req_if.sink   req_chan,
   gma_rsp_if.source rsp_chan,
   gma_csr_if.sink   csr_chan
);
   import gma_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DRAIN  = 3'd2;
   localparam logic [2:0] ST_DECIDE = 3'd3;
   localparam logic [2:0] ST_TERM   = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [CFG_W-1:0]        rows_cfg_ff, cols_cfg_ff, match_cfg_ff;
   logic [DIM_W-1:0]        nr_ff, nr_in, nc_ff, nc_in;
   logic [CFG_W-1:0]        rounds_ff, rounds_in, round_ff, round_in;
   logic [RIDX_W-1:0]       r_ff, r_in;
   logic [CIDX_W-1:0]       c_ff, c_in;
   logic [ADDR_W-1:0]       base_ff, base_in;
   logic [MAX_ROWS-1:0]     row_taken_ff, row_taken_in;
   logic [MAX_COLS-1:0]     col_taken_ff, col_taken_in;
   logic                    tag_valid_ff, tag_valid_in, tag_elig_ff, tag_elig_in;
   logic [RIDX_W-1:0]       tag_r_ff, tag_r_in, br_ff, br_in;
   logic [CIDX_W-1:0]       tag_c_ff, tag_c_in, bc_ff, bc_in;
   logic                    have_ff, have_in;
   logic signed [SCORE_BITS-1:0] best_ff, best_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]        rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0]        rsp_col_ff, rsp_col_in;
   logic                    rsp_found_ff, rsp_found_in, rsp_last_ff, rsp_last_in;

   logic                    req_acc, out_free, load_ok, last_col, last_row;
   logic [DIM_W-1:0]        clamp_rows, clamp_cols;
   logic [CFG_W-1:0]        clamp_rounds;
   logic                    ram_we;
   logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
   logic [SCORE_BITS-1:0]   ram_rdata;

   gma_ram #(.WIDTH(SCORE_BITS), .DEPTH(DEPTH)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (fit_score(req_chan.score)),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.match_row = rsp_row_ff;
   assign rsp_chan.match_col = rsp_col_ff;
   assign rsp_chan.found     = rsp_found_ff;
   assign rsp_chan.last      = rsp_last_ff;

   assign clamp_rows   = ({1'b0, rows_cfg_ff} > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS)
                                                                   : {1'b0, rows_cfg_ff};
   assign clamp_cols   = ({1'b0, cols_cfg_ff} > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS)
                                                                   : {1'b0, cols_cfg_ff};
   assign clamp_rounds = (match_cfg_ff > CFG_W'(PAIR_LIMIT)) ? CFG_W'(PAIR_LIMIT)
                                                              : match_cfg_ff;

   assign load_ok   = ({2'b00, req_chan.row} < DIM_W'(MAX_ROWS)) &&
                      ({2'b00, req_chan.col} < DIM_W'(MAX_COLS));
   assign ram_waddr = ADDR_W'(req_chan.row) * ADDR_W'(MAX_COLS) + ADDR_W'(req_chan.col);
   assign ram_raddr = base_ff + ADDR_W'(c_ff);
   assign last_col  = (DIM_W'(c_ff) == nc_ff - DIM_W'(1));
   assign last_row  = (DIM_W'(r_ff) == nr_ff - DIM_W'(1));

   always_comb begin
      state_in     = state_ff;
      nr_in        = nr_ff;
      nc_in        = nc_ff;
      rounds_in    = rounds_ff;
      round_in     = round_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      base_in      = base_ff;
      row_taken_in = row_taken_ff;
      col_taken_in = col_taken_ff;
      tag_valid_in = 1'b0;
      tag_elig_in  = tag_elig_ff;
      tag_r_in     = tag_r_ff;
      tag_c_in     = tag_c_ff;
      have_in      = have_ff;
      best_in      = best_ff;
      br_in        = br_ff;
      bc_in        = bc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_found_in = rsp_found_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      // Read data is registered and arrives in the cycle after its address; strict greater keeps the
      // first entry in row-major order on ties.
      if (tag_valid_ff && tag_elig_ff && (!have_ff || $signed(ram_rdata) > best_ff)) begin
         have_in = 1'b1;
         best_in = $signed(ram_rdata);
         br_in   = tag_r_ff;
         bc_in   = tag_c_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_chan.cmd == CMD_LOAD) begin
                  ram_we = load_ok;
               end else begin
                  row_taken_in = '0;
                  col_taken_in = '0;
                  round_in     = '0;
                  nr_in        = clamp_rows;
                  nc_in        = clamp_cols;
                  rounds_in    = clamp_rounds;
                  r_in         = '0;
                  c_in         = '0;
                  base_in      = '0;
                  have_in      = 1'b0;
                  if (clamp_rows == '0 || clamp_cols == '0 || clamp_rounds == '0) begin
                     state_in = ST_TERM;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            tag_valid_in = 1'b1;
            tag_elig_in  = !row_taken_ff[r_ff] && !col_taken_ff[c_ff];
            tag_r_in     = r_ff;
            tag_c_in     = c_ff;
            if (last_col) begin
               c_in    = '0;
               r_in    = r_ff + RIDX_W'(1);
               base_in = base_ff + ADDR_W'(MAX_COLS);
               if (last_row) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               c_in = c_ff + CIDX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!have_ff || best_ff[SCORE_BITS-1]) begin
               state_in = ST_TERM;
            end else if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_row_in          = ROW_W'(br_ff);
               rsp_col_in          = COL_W'(bc_ff);
               rsp_found_in        = 1'b1;
               rsp_last_in         = 1'b0;
               row_taken_in[br_ff] = 1'b1;
               col_taken_in[bc_ff] = 1'b1;
               round_in            = round_ff + CFG_W'(1);
               r_in                = '0;
               c_in                = '0;
               base_in             = '0;
               have_in             = 1'b0;
               if (round_ff + CFG_W'(1) == rounds_ff) begin
                  state_in = ST_TERM;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_TERM: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = '0;
               rsp_col_in   = '0;
               rsp_found_in = 1'b0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rows_cfg_ff  <= ROWS_RESET;
         cols_cfg_ff  <= COLS_RESET;
         match_cfg_ff <= MATCH_RESET;
         round_ff     <= '0;
         row_taken_ff <= '0;
         col_taken_ff <= '0;
         tag_valid_ff <= 1'b0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         row_taken_ff <= row_taken_in;
         col_taken_ff <= col_taken_in;
         tag_valid_ff <= tag_valid_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_chan.index)
               REG_ROWS:  rows_cfg_ff  <= csr_chan.data;
               REG_COLS:  cols_cfg_ff  <= csr_chan.data;
               REG_MATCH: match_cfg_ff <= csr_chan.data;
               default:   ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      nr_ff        <= nr_in;
      nc_ff        <= nc_in;
      rounds_ff    <= rounds_in;
      r_ff         <= r_in;
      c_ff         <= c_in;
      base_ff      <= base_in;
      tag_elig_ff  <= tag_elig_in;
      tag_r_ff     <= tag_r_in;
      tag_c_ff     <= tag_c_in;
      best_ff      <= best_in;
      br_ff        <= br_in;
      bc_ff        <= bc_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_found_ff <= rsp_found_in;
      rsp_last_ff  <= rsp_last_in;
   end

`ifndef NO_ASSERTIONS
   // Every emitted pair takes exactly one row and one column.
   a_row_count: assert property (@(posedge clock) disable iff (reset)
      $countones(row_taken_ff) == int'(round_ff))
      else $error("row mask does not match the number of emitted pairs");

   a_col_count: assert property (@(posedge clock) disable iff (reset)
      $countones(col_taken_ff) == int'(round_ff))
      else $error("column mask does not match the number of emitted pairs");

   a_scan_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |=> tag_valid_ff)
      else $error("scan read did not reach the compare stage");

   a_run_start: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_chan.cmd == CMD_RUN) |=> (state_ff != ST_IDLE))
      else $error("run transaction did not start the sequencer");

   a_round_limit: assert property (@(posedge clock) disable iff (reset)
      int'(round_ff) <= PAIR_LIMIT)
      else $error("round count exceeds the pair limit");
`endif

endmodule
